[hw/rtl/scpa_pkg.sv]
// Package: constants, types and codes shared by the pool allocator.
`default_nettype none
package scpa_pkg;
   localparam int NumClasses  = 8;
   localparam int PoolBytes   = 65536;
   localparam int HeaderBytes = 16;
   localparam int RegCount    = 8;
   localparam int PoolLimit   = (PoolBytes > 65536) ? 65536 : PoolBytes;
   localparam int HdrDepth    = PoolLimit / HeaderBytes;
   localparam int UsedClasses = (NumClasses > RegCount) ? RegCount : NumClasses;
   localparam int HdrShift    = $clog2(HeaderBytes);
   localparam int BlkW        = $clog2(HdrDepth);
   localparam int LinkW       = BlkW + 1;
   localparam int CntW        = 13;
   localparam int BumpW       = 17;
   localparam int QDepth      = 2;

   typedef logic [1:0] status_type;
   localparam status_type StOk        = 2'd0;
   localparam status_type StNoClass   = 2'd1;
   localparam status_type StExhausted = 2'd2;
   localparam status_type StBadFree   = 2'd3;

   localparam logic CmdAlloc = 1'b0;
   localparam logic CmdFree  = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_FAIL
   } op_type;

   typedef struct packed {
      op_type            op;
      status_type        fail_status;
      logic [2:0]        cls;
      logic [BlkW-1:0]   blk;
      logic [15:0]       addr;
   } work_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DONE,
      ST_CLEAR
   } state_type;

   localparam logic [15:0] ClassReset [RegCount] = '{
      16'd16, 16'd32, 16'd64, 16'd128, 16'd256, 16'd512, 16'd1024, 16'd2048
   };
endpackage
`default_nettype wire

[hw/rtl/scpa_front.sv]
// Front end: accept requests, check sizes and addresses, queue classified work.
`default_nettype none
module scpa_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [2:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [15:0]          req_alloc_size,
   input  wire logic [15:0]          req_block_addr,
   output logic                      wq_valid,
   input  wire logic                 wq_ready,
   output scpa_pkg::work_type        wq_data,
   output logic [15:0]               class_size_sel
);
   import scpa_pkg::*;

   localparam int QPtrW = $clog2(QDepth);

   logic [15:0] class_size_ff [RegCount];
   work_type    q_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPtrW:0]   count_ff;
   work_type    item;
   logic        push, pop;
   logic [3:0]  found;
   logic [15:0] hdr;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCount; i++) class_size_ff[i] <= ClassReset[i];
      end else if (csr_we) begin
         class_size_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      found = 4'(RegCount);
      for (int c = UsedClasses - 1; c >= 0; c--) begin
         if (req_alloc_size <= class_size_ff[c]) found = 4'(c);
      end
      hdr = req_block_addr - 16'(HeaderBytes);
      item.op          = OP_FAIL;
      item.fail_status = StNoClass;
      item.cls         = found[2:0];
      item.addr        = req_block_addr;
      item.blk         = hdr[HdrShift +: BlkW];
      if (req_cmd == CmdFree) begin
         item.fail_status = StBadFree;
         item.cls = '0;
         if (req_block_addr >= 16'(HeaderBytes) && hdr[HdrShift-1:0] == '0
             && (32'(hdr) >> HdrShift) < 32'(HdrDepth)) item.op = OP_FREE;
      end else if (req_alloc_size != 16'd0 && !found[3]) begin
         item.op = OP_ALLOC;
      end
   end

   assign req_ready = (count_ff != (QPtrW+1)'(QDepth));
   assign push = req_valid && req_ready;
   assign wq_valid = (count_ff != '0);
   assign pop = wq_valid && wq_ready;
   assign wq_data = q_ff[rd_ptr_ff];
   assign class_size_sel = class_size_ff[wq_data.cls];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
      end
   end
endmodule
`default_nettype wire

[hw/rtl/scpa_back.sv]
// Back end: header store, free lists, bump pointer and result register.
`default_nettype none
module scpa_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wq_valid,
   output logic                      wq_ready,
   input  scpa_pkg::work_type        wq_data,
   input  wire logic [15:0]          class_size_sel,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [15:0]               rsp_payload_addr,
   output logic [2:0]                rsp_size_class,
   output logic [12:0]               rsp_class_in_use
);
   import scpa_pkg::*;

   state_type state_ff, state_in;
   logic [BumpW-1:0] bump_ff;
   logic [LinkW-1:0] head_ff [RegCount];
   logic [CntW-1:0]  used_ff [RegCount];
   logic [CntW-1:0]  made_ff [RegCount];
   logic             halloc_mem [HdrDepth];
   logic [2:0]       hcls_mem [HdrDepth];
   logic [LinkW-1:0] hnext_mem [HdrDepth];
   logic             halloc_rd_ff;
   logic [2:0]       hcls_rd_ff;
   logic [LinkW-1:0] hnext_rd_ff;
   logic [BlkW-1:0]  clr_ff;
   logic [BlkW-1:0]  rd_addr;
   logic [1:0]  st_ff;
   logic [15:0] pa_ff;
   logic [2:0]  sc_ff;
   logic [12:0] iu_ff;
   logic        take, exec, pop_head;
   logic [LinkW-1:0] head;
   logic [2:0]  fcls;
   logic [BumpW-1:0] step;
   logic [BumpW:0]   bump_next;
   logic [BlkW-1:0]  bblk;
   logic [15:0] round_sz;

   assign head = head_ff[wq_data.cls];
   assign pop_head = head != '0 && 32'(head) <= 32'(HdrDepth);
   assign rd_addr = (wq_data.op == OP_FREE) ? wq_data.blk : BlkW'(head - 1'b1);
   assign round_sz = 16'((32'(class_size_sel) + HeaderBytes - 1) >> HdrShift << HdrShift);
   assign step = BumpW'(HeaderBytes) + BumpW'(round_sz);
   assign bump_next = (BumpW+1)'(bump_ff) + (BumpW+1)'(step);
   assign bblk = BlkW'(bump_ff >> HdrShift);
   assign fcls = hcls_rd_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && wq_valid) begin
         halloc_rd_ff <= halloc_mem[rd_addr];
         hcls_rd_ff  <= hcls_mem[rd_addr];
         hnext_rd_ff <= hnext_mem[rd_addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      take = 1'b0;
      exec = 1'b0;
      wq_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: if (&clr_ff) state_in = ST_IDLE;
         ST_IDLE: if (wq_valid) state_in = ST_READ;
         ST_READ: begin
            exec = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: if (!rsp_valid || rsp_ready) begin
            take = 1'b1;
            wq_ready = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff <= '0;
         clr_ff <= '0;
         for (int i = 0; i < RegCount; i++) begin
            head_ff[i] <= '0;
            used_ff[i] <= '0;
            made_ff[i] <= '0;
         end
      end else if (state_ff == ST_CLEAR) begin
         halloc_mem[clr_ff] <= 1'b0;
         clr_ff <= clr_ff + 1'b1;
      end else if (exec) begin
         case (wq_data.op)
            OP_ALLOC: begin
               st_ff <= StOk;
               sc_ff <= wq_data.cls;
               if (pop_head) begin
                  head_ff[wq_data.cls] <= hnext_rd_ff;
                  halloc_mem[rd_addr] <= 1'b1;
                  hnext_mem[rd_addr] <= '0;
                  used_ff[wq_data.cls] <= used_ff[wq_data.cls] + 1'b1;
                  iu_ff <= used_ff[wq_data.cls] + 1'b1;
                  pa_ff <= 16'((32'(rd_addr) + 1) << HdrShift);
               end else if (32'(bump_next) > 32'(PoolLimit)) begin
                  st_ff <= StExhausted;
                  pa_ff <= '0;
                  iu_ff <= used_ff[wq_data.cls];
               end else begin
                  bump_ff <= bump_next[BumpW-1:0];
                  made_ff[wq_data.cls] <= made_ff[wq_data.cls] + 1'b1;
                  hcls_mem[bblk] <= wq_data.cls;
                  halloc_mem[bblk] <= 1'b1;
                  hnext_mem[bblk] <= '0;
                  used_ff[wq_data.cls] <= used_ff[wq_data.cls] + 1'b1;
                  iu_ff <= used_ff[wq_data.cls] + 1'b1;
                  pa_ff <= 16'((32'(bblk) + 1) << HdrShift);
               end
            end
            OP_FREE: begin
               if (halloc_rd_ff) begin
                  halloc_mem[wq_data.blk] <= 1'b0;
                  hnext_mem[wq_data.blk] <= head_ff[fcls];
                  head_ff[fcls] <= LinkW'(wq_data.blk) + 1'b1;
                  st_ff <= StOk;
                  pa_ff <= wq_data.addr;
                  sc_ff <= fcls;
                  if (used_ff[fcls] != '0) begin
                     used_ff[fcls] <= used_ff[fcls] - 1'b1;
                     iu_ff <= used_ff[fcls] - 1'b1;
                  end else begin
                     iu_ff <= '0;
                  end
               end else begin
                  st_ff <= StBadFree;
                  pa_ff <= '0;
                  sc_ff <= '0;
                  iu_ff <= '0;
               end
            end
            default: begin
               st_ff <= wq_data.fail_status;
               pa_ff <= '0;
               sc_ff <= '0;
               iu_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (take) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_status <= st_ff;
         rsp_payload_addr <= pa_ff;
         rsp_size_class <= sc_ff;
         rsp_class_in_use <= iu_ff;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/size_class_pool_allocator_top.sv]
// Top level: size-class pool allocator with decoupled front and back ends.
//  channel  | handshake             | payload
//  req      | req_valid/req_ready   | cmd, alloc_size, block_addr
//  rsp      | rsp_valid/rsp_ready   | status, payload_addr, size_class, class_in_use
//  csr      | csr_we                | csr_index, csr_wdata
// The back end handles one request at a time, in order: header memory read, update, result load.
// The front queue holds two classified requests while the back end works.
// Reset is synchronous; the back end then clears the 4096 header valid bits,
// one per cycle, before it takes work, while the front queue fills.
// A stalled result holds the back end; the front keeps taking requests until full.
`default_nettype none
module size_class_pool_allocator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [15:0] req_alloc_size,
   input  wire logic [15:0] req_block_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_payload_addr,
   output logic [2:0]       rsp_size_class,
   output logic [12:0]      rsp_class_in_use
);
   import scpa_pkg::*;

   logic     wq_valid, wq_ready;
   work_type wq_data;
   logic [15:0] class_size_sel;

   scpa_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_cmd, .req_alloc_size, .req_block_addr,
      .wq_valid, .wq_ready, .wq_data, .class_size_sel
   );

   scpa_back u_back (
      .clock, .reset, .wq_valid, .wq_ready, .wq_data, .class_size_sel,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_payload_addr,
      .rsp_size_class, .rsp_class_in_use
   );

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StOk |-> rsp_payload_addr == '0)
      else $error("error result with nonzero address");
   a_ok_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StOk |-> rsp_payload_addr[HdrShift-1:0] == '0)
      else $error("unaligned payload address");
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      wq_ready |-> wq_valid)
      else $error("back end pops empty queue");
endmodule
`default_nettype wire

[bench/tb_size_class_pool_allocator_top.sv]
// Testbench for the size-class pool allocator: directed table, then random traffic phases.
`default_nettype none
module tb_size_class_pool_allocator_top;
   import scpa_pkg::*;

   typedef struct packed {
      status_type  st;
      logic [15:0] pa;
      logic [2:0]  cl;
      logic [12:0] in_use;
   } alloc_rsp_t;

   typedef struct packed {
      logic        cmd;
      logic [15:0] sz;
      logic [15:0] ad;
      logic        chk;
      alloc_rsp_t  want;
   } dir_row_t;

   localparam int IdleLimit = 20000;
   localparam int NumPhases = 7;
   localparam int PhaseItems = 115;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CmdAlloc;
   logic [15:0] req_alloc_size = '0;
   logic [15:0] req_block_addr = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_payload_addr;
   logic [2:0]  rsp_size_class;
   logic [12:0] rsp_class_in_use;

   size_class_pool_allocator_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // allocator image
   logic [15:0] class_sz [RegCount];
   int          bump_ptr;
   int          list_head [RegCount];
   bit          hdr_used [HdrDepth];
   logic [2:0]  hdr_cls [HdrDepth];
   int          hdr_link [HdrDepth];
   int          cls_in_use [RegCount];
   logic [15:0] live_addrs [$];

   alloc_rsp_t  pending_rsp [$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_go = 1'b0;
   bit          hold_seen = 1'b0;
   int          hold_cnt = 0;
   int          idle_cycles = 0;
   int          errors = 0;
   int          n_rsp = 0;
   int          n_st [4] = '{0, 0, 0, 0};

   task automatic predict_pool(input logic cmd, input logic [15:0] sz, input logic [15:0] ad,
                               output alloc_rsp_t r);
      int c;
      int blk;
      int step;
      int hdr;
      r = '{StNoClass, 16'd0, 3'd0, 13'd0};
      if (cmd == CmdAlloc) begin
         if (sz == 0) return;
         c = -1;
         for (int i = 0; i < UsedClasses; i++)
            if (c < 0 && sz <= class_sz[i]) c = i;
         if (c < 0) return;
         if (list_head[c] != 0 && list_head[c] <= HdrDepth) begin
            blk = list_head[c] - 1;
            list_head[c] = hdr_link[blk];
         end else begin
            step = HeaderBytes + (int'(class_sz[c]) + HeaderBytes - 1) / HeaderBytes * HeaderBytes;
            if (bump_ptr + step > PoolLimit) begin
               r = '{StExhausted, 16'd0, 3'(c), 13'(cls_in_use[c])};
               return;
            end
            blk = bump_ptr / HeaderBytes;
            bump_ptr += step;
            hdr_cls[blk] = 3'(c);
         end
         hdr_used[blk] = 1'b1;
         hdr_link[blk] = 0;
         cls_in_use[c]++;
         r = '{StOk, 16'(blk * HeaderBytes + HeaderBytes), 3'(c), 13'(cls_in_use[c])};
         live_addrs.push_back(r.pa);
      end else begin
         r.st = StBadFree;
         if (ad < HeaderBytes) return;
         hdr = int'(ad) - HeaderBytes;
         blk = hdr / HeaderBytes;
         if (hdr % HeaderBytes != 0 || blk >= HdrDepth || !hdr_used[blk]) return;
         c = hdr_cls[blk];
         hdr_used[blk] = 1'b0;
         hdr_link[blk] = list_head[c];
         list_head[c] = blk + 1;
         if (cls_in_use[c] > 0) cls_in_use[c]--;
         r = '{StOk, ad, 3'(c), 13'(cls_in_use[c])};
         for (int i = 0; i < live_addrs.size(); i++)
            if (live_addrs[i] == ad) begin
               live_addrs.delete(i);
               break;
            end
      end
   endtask

   task automatic send_req(input logic cmd, input logic [15:0] sz, input logic [15:0] ad,
                           input bit use_want, input alloc_rsp_t want);
      alloc_rsp_t r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_alloc_size <= sz;
      req_block_addr <= ad;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pool(cmd, sz, ad, r);
      pending_rsp.push_back(use_want ? want : r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_classes(input logic [15:0] v [RegCount]);
      for (int i = 0; i < RegCount; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         class_sz[i] = v[i];
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_cnt <= 300;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      alloc_rsp_t e;
      if (!reset && ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected transfer on rsp");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            n_rsp++;
            n_st[e.st]++;
            if (rsp_status !== e.st) begin
               $error("status expected %0d actual %0d", e.st, rsp_status);
               errors++;
            end
            if (rsp_payload_addr !== e.pa) begin
               $error("payload_addr expected %0d actual %0d", e.pa, rsp_payload_addr);
               errors++;
            end
            if (rsp_size_class !== e.cl) begin
               $error("size_class expected %0d actual %0d", e.cl, rsp_size_class);
               errors++;
            end
            if (rsp_class_in_use !== e.in_use) begin
               $error("class_in_use expected %0d actual %0d", e.in_use, rsp_class_in_use);
               errors++;
            end
         end
      end
   end

   dir_row_t dir_tab [20] = '{
      '{CmdAlloc, 16'd0,     16'd0,     1'b1, '{StNoClass, 16'd0, 3'd0, 13'd0}},
      '{CmdAlloc, 16'd1,     16'd0,     1'b1, '{StOk, 16'd16, 3'd0, 13'd1}},
      '{CmdAlloc, 16'd16,    16'd0,     1'b1, '{StOk, 16'd48, 3'd0, 13'd2}},
      '{CmdAlloc, 16'd17,    16'd0,     1'b1, '{StOk, 16'd80, 3'd1, 13'd1}},
      '{CmdAlloc, 16'd2048,  16'd0,     1'b1, '{StOk, 16'd128, 3'd7, 13'd1}},
      '{CmdAlloc, 16'd2049,  16'd0,     1'b1, '{StNoClass, 16'd0, 3'd0, 13'd0}},
      '{CmdAlloc, 16'd65535, 16'd65535, 1'b1, '{StNoClass, 16'd0, 3'd0, 13'd0}},
      '{CmdFree,  16'd0,     16'd0,     1'b1, '{StBadFree, 16'd0, 3'd0, 13'd0}},
      '{CmdFree,  16'd65535, 16'd15,    1'b1, '{StBadFree, 16'd0, 3'd0, 13'd0}},
      '{CmdFree,  16'd0,     16'd24,    1'b1, '{StBadFree, 16'd0, 3'd0, 13'd0}},
      '{CmdFree,  16'd0,     16'd65535, 1'b1, '{StBadFree, 16'd0, 3'd0, 13'd0}},
      '{CmdFree,  16'd0,     16'd16,    1'b1, '{StOk, 16'd16, 3'd0, 13'd1}},
      '{CmdFree,  16'd0,     16'd16,    1'b1, '{StBadFree, 16'd0, 3'd0, 13'd0}},
      '{CmdAlloc, 16'd10,    16'd0,     1'b1, '{StOk, 16'd16, 3'd0, 13'd2}},
      '{CmdFree,  16'd0,     16'd65520, 1'b1, '{StBadFree, 16'd0, 3'd0, 13'd0}},
      '{CmdFree,  16'd0,     16'd48,    1'b0, '{StOk, 16'd0, 3'd0, 13'd0}},
      '{CmdFree,  16'd0,     16'd80,    1'b0, '{StOk, 16'd0, 3'd0, 13'd0}},
      '{CmdFree,  16'd0,     16'd128,   1'b0, '{StOk, 16'd0, 3'd0, 13'd0}},
      '{CmdAlloc, 16'd100,   16'd0,     1'b0, '{StOk, 16'd0, 3'd0, 13'd0}},
      '{CmdAlloc, 16'd2000,  16'd0,     1'b0, '{StOk, 16'd0, 3'd0, 13'd0}}
   };

   initial begin
      logic [15:0] cfg [RegCount];
      logic [15:0] sz;
      logic [15:0] ad;
      int          max_cs;
      int          pick;
      for (int i = 0; i < RegCount; i++) begin
         class_sz[i] = ClassReset[i];
         list_head[i] = 0;
         cls_in_use[i] = 0;
      end
      for (int i = 0; i < HdrDepth; i++) begin
         hdr_used[i] = 1'b0;
         hdr_cls[i] = '0;
         hdr_link[i] = 0;
      end
      bump_ptr = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i])
         send_req(dir_tab[i].cmd, dir_tab[i].sz, dir_tab[i].ad, dir_tab[i].chk, dir_tab[i].want);
      drain();
      cfg = class_sz;
      cfg[0] = 16'd20;
      cfg[7] = 16'd65520;
      write_classes(cfg);
      send_req(CmdAlloc, 16'd20, 16'd0, 1'b0, '0);
      send_req(CmdAlloc, 16'd65520, 16'd0, 1'b0, '0);
      send_req(CmdAlloc, 16'd30000, 16'd0, 1'b0, '0);

      for (int p = 0; p < NumPhases; p++) begin
         drain();
         for (int i = 0; i < RegCount; i++) begin
            case (p)
               0: cfg[i] = ClassReset[i];
               1: cfg[i] = 16'd16;
               2: cfg[i] = 16'(16 * (i + 1));
               3: cfg[i] = 16'd65520;
               4: cfg[i] = (i == 0) ? 16'(16 * $urandom_range(1, 8))
                                    : 16'(cfg[i-1] + 16 * $urandom_range(1, 64));
               5: cfg[i] = 16'($urandom_range(16, 65520));
               default: cfg[i] = ClassReset[i];
            endcase
         end
         write_classes(cfg);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         if (p == 2) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_go = 1'b1;
         end
         max_cs = 16;
         for (int i = 0; i < UsedClasses; i++)
            if (class_sz[i] > max_cs) max_cs = class_sz[i];
         for (int n = 0; n < PhaseItems; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               case ($urandom_range(9))
                  0: sz = 16'd0;
                  1: sz = 16'($urandom);
                  2: sz = class_sz[$urandom_range(UsedClasses - 1)];
                  default: sz = 16'($urandom_range(1, max_cs));
               endcase
               send_req(CmdAlloc, sz, 16'($urandom), 1'b0, '0);
            end else if (pick < 90 && live_addrs.size() != 0) begin
               ad = live_addrs[$urandom_range(live_addrs.size() - 1)];
               send_req(CmdFree, 16'($urandom), ad, 1'b0, '0);
            end else begin
               ad = $urandom_range(1) ? 16'($urandom) : 16'(16 * $urandom_range(1, 4095));
               send_req(CmdFree, 16'($urandom), ad, 1'b0, '0);
            end
         end
      end
      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d results over %0d class settings with idle and stall mixes.",
               n_rsp, NumPhases + 2);
      $display("Status mix: ok %0d, no class %0d, exhausted %0d, bad free %0d.",
               n_st[StOk], n_st[StNoClass], n_st[StExhausted], n_st[StBadFree]);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
